@@ rtl/core/uer_pkg.sv @@
// Package: types, register codes and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned DistBits   = 12;
  localparam int unsigned ChirpBits  = 8;
  localparam int unsigned SettleBits = 8;
  localparam int unsigned MarginBits = 10;
  localparam int unsigned TimeoutBits = 10;
  localparam int unsigned CfgDataBits = 10;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CountBitsDefault = 10;

  localparam logic [DistBits-1:0]    NoEcho         = 12'hFFF;
  localparam logic [ChirpBits-1:0]   ChirpReset     = 8'd8;
  localparam logic [SettleBits-1:0]  SettleReset    = 8'd20;
  localparam logic [MarginBits-1:0]  MarginReset    = 10'd32;
  localparam logic [TimeoutBits-1:0] TimeoutReset   = 10'd800;

  localparam logic OpStart = 1'b0;
  localparam logic OpTick  = 1'b1;

  localparam logic [CfgIdxBits-1:0] RegChirp   = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegSettle  = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegMargin  = 2'd2;
  localparam logic [CfgIdxBits-1:0] RegTimeout = 2'd3;

  typedef enum logic [1:0] {
    PhIdle   = 2'd0,
    PhChirp  = 2'd1,
    PhSettle = 2'd2,
    PhSample = 2'd3
  } phase_e;

  typedef struct packed {
    logic                  opcode;
    logic [SampleBits-1:0] sample;
  } uer_in_t;

  typedef struct packed {
    logic                burst_on;
    logic                sampling;
    logic                channel;
    logic [DistBits-1:0] left_distance;
    logic [DistBits-1:0] right_distance;
    logic                done_res;
    logic                timed_out;
  } uer_out_t;

  typedef struct packed {
    logic [ChirpBits-1:0]   chirp_cycles;
    logic [SettleBits-1:0]  settle_cycles;
    logic [MarginBits-1:0]  echo_margin;
    logic [TimeoutBits-1:0] timeout_count;
  } uer_cfg_t;

endpackage

@@ rtl/core/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger: two-channel alternating chirp and echo timing sequencer.
//
// Each beat is either a start (flip channel, arm a chirp) or a tick carrying an ADC
// sample, and produces exactly one result beat. A beat passes an input register,
// one pass of compare-and-count logic, and a result register; one beat is taken
// every cycle, holding off only when both registers are full and the result side
// stalls. Registers may be written at any time the block is idle.
module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int unsigned CountBits = CountBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  uer_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output uer_out_t               out_data_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [CfgDataBits-1:0] cfg_data_i
);

  logic     in_valid_q;
  uer_in_t  in_q;
  logic     out_valid_q;
  uer_out_t out_q;
  uer_cfg_t cfg_q;
  uer_out_t res;
  logic     advance;
  logic     take;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign take        = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  uer_seq #(
    .CountBits(CountBits)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_q),
    .cfg_i (cfg_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chirp_cycles  <= ChirpReset;
      cfg_q.settle_cycles <= SettleReset;
      cfg_q.echo_margin   <= MarginReset;
      cfg_q.timeout_count <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegChirp:   cfg_q.chirp_cycles  <= cfg_data_i[ChirpBits-1:0];
        RegSettle:  cfg_q.settle_cycles <= cfg_data_i[SettleBits-1:0];
        RegMargin:  cfg_q.echo_margin   <= cfg_data_i[MarginBits-1:0];
        RegTimeout: cfg_q.timeout_count <= cfg_data_i[TimeoutBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

@@ rtl/core/uer_seq.sv @@
// Measurement sequencer: phase state, sample counter, echo detect and range store.
module uer_seq import uer_pkg::*; #(
  parameter int unsigned CountBits = CountBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  uer_in_t  item_i,
  input  uer_cfg_t cfg_i,
  output uer_out_t res_o
);

  localparam int unsigned ThrBits = ((SampleBits > MarginBits) ? SampleBits : MarginBits) + 1;
  localparam int unsigned CmpW    = (CountBits > DistBits) ? CountBits : DistBits;
  localparam int unsigned ToW     = (CountBits > TimeoutBits) ? CountBits : TimeoutBits;

  phase_e               phase_q, phase_d;
  logic                 chan_q, chan_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [ThrBits-1:0]   thr_q, thr_d;
  logic                 first_q, first_d;
  logic [DistBits-1:0]  left_q, left_d;
  logic [DistBits-1:0]  right_q, right_d;

  logic [CountBits-1:0] cnt_inc;
  logic [CmpW-1:0]      cnt_ext;
  logic [DistBits-1:0]  cnt_dist;
  logic                 echo;
  logic                 tout;
  logic                 burst;
  logic                 samp;
  logic                 done;

  assign cnt_inc  = cnt_q + CountBits'(1);
  assign cnt_ext  = CmpW'(cnt_inc);
  assign cnt_dist = (cnt_ext > CmpW'(NoEcho)) ? NoEcho : cnt_ext[DistBits-1:0];
  assign echo     = !first_q && (ThrBits'(item_i.sample) > thr_q);
  assign tout     = ToW'(cnt_inc) > ToW'(cfg_i.timeout_count);

  always_comb begin
    phase_d = phase_q;
    chan_d  = chan_q;
    cnt_d   = cnt_q;
    thr_d   = thr_q;
    first_d = first_q;
    left_d  = left_q;
    right_d = right_q;
    burst   = 1'b0;
    samp    = 1'b0;
    done    = 1'b0;
    if (item_i.opcode == OpStart) begin
      chan_d  = ~chan_q;
      cnt_d   = CountBits'(cfg_i.chirp_cycles);
      phase_d = PhChirp;
    end else begin
      case (phase_q)
        PhChirp: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - CountBits'(1);
            burst = 1'b1;
          end else begin
            cnt_d   = CountBits'(cfg_i.settle_cycles);
            phase_d = PhSettle;
          end
        end
        PhSettle: begin
          if (cnt_q == '0) begin
            phase_d = PhSample;
            cnt_d   = '1;
            first_d = 1'b1;
            thr_d   = '0;
          end else begin
            cnt_d = cnt_q - CountBits'(1);
          end
        end
        PhSample: begin
          samp  = 1'b1;
          cnt_d = cnt_inc;
          if (echo) begin
            if (chan_q) right_d = cnt_dist;
            else        left_d  = cnt_dist;
            phase_d = PhIdle;
            done    = 1'b1;
          end else begin
            thr_d   = ThrBits'(item_i.sample) + ThrBits'(cfg_i.echo_margin);
            first_d = 1'b0;
          end
          if (tout) begin
            if (chan_q) right_d = NoEcho;
            else        left_d  = NoEcho;
            phase_d = PhIdle;
            done    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o.burst_on       = burst;
    res_o.sampling       = samp;
    res_o.channel        = chan_d;
    res_o.left_distance  = left_d;
    res_o.right_distance = right_d;
    res_o.done_res       = done;
    res_o.timed_out      = samp && tout;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      chan_q  <= 1'b0;
      cnt_q   <= '0;
      thr_q   <= '0;
      first_q <= 1'b1;
      left_q  <= '0;
      right_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      cnt_q   <= cnt_d;
      thr_q   <= thr_d;
      first_q <= first_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

endmodule

@@ tb/tb_ultrasonic_echo_ranger.sv @@
// Testbench for ultrasonic_echo_ranger: directed and random beats checked against a predictor.
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned RandomBeats = 900;
  localparam int MaxSample = (1 << SampleBits) - 1;

  class range_board;
    logic [ChirpBits-1:0]        chirp_len;
    logic [SettleBits-1:0]       settle_len;
    logic [MarginBits-1:0]       margin;
    logic [TimeoutBits-1:0]      timeout;
    phase_e                      phase;
    logic                        chan;
    logic [CountBitsDefault-1:0] count;
    logic [SampleBits:0]         last_threshold;
    logic                        first_pending;
    logic [DistBits-1:0]         left_dist;
    logic [DistBits-1:0]         right_dist;
    uer_out_t                    expected_readings[$];
    int unsigned errors, checked, busy_beats, echoes, timeouts, abandons, reg_writes;

    function new();
      chirp_len = ChirpReset;
      settle_len = SettleReset;
      margin = MarginReset;
      timeout = TimeoutReset;
      phase = PhIdle;
      chan = 1'b0;
      count = '0;
      last_threshold = '0;
      first_pending = 1'b1;
      left_dist = '0;
      right_dist = '0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
      case (idx)
        RegChirp:   chirp_len = val[ChirpBits-1:0];
        RegSettle:  settle_len = val[SettleBits-1:0];
        RegMargin:  margin = val[MarginBits-1:0];
        RegTimeout: timeout = val[TimeoutBits-1:0];
        default: ;
      endcase
      reg_writes++;
    endfunction

    function void set_distance(logic [DistBits-1:0] d);
      if (chan) right_dist = d;
      else left_dist = d;
    endfunction

    function void note_beat(uer_in_t beat);
      uer_out_t want;
      want = '0;
      if (beat.opcode == OpStart || phase != PhIdle) busy_beats++;
      if (beat.opcode == OpStart) begin
        if (phase != PhIdle) abandons++;
        chan = ~chan;
        count = CountBitsDefault'(chirp_len);
        phase = PhChirp;
      end else begin
        case (phase)
          PhChirp: begin
            if (count != 0) begin
              count = count - CountBitsDefault'(1);
              want.burst_on = 1'b1;
            end else begin
              count = CountBitsDefault'(settle_len);
              phase = PhSettle;
            end
          end
          PhSettle: begin
            if (count == 0) begin
              phase = PhSample;
              count = '1;
              first_pending = 1'b1;
              last_threshold = '0;
            end else begin
              count = count - CountBitsDefault'(1);
            end
          end
          PhSample: begin
            want.sampling = 1'b1;
            count = count + CountBitsDefault'(1);
            if (!first_pending && {1'b0, beat.sample} > last_threshold) begin
              set_distance(DistBits'(count));
              phase = PhIdle;
              want.done_res = 1'b1;
            end else begin
              last_threshold = {1'b0, beat.sample} + (SampleBits + 1)'(margin);
              first_pending = 1'b0;
            end
            if (count > timeout) begin
              set_distance(NoEcho);
              phase = PhIdle;
              want.done_res = 1'b1;
              want.timed_out = 1'b1;
            end
            if (want.timed_out) timeouts++;
            else if (want.done_res) echoes++;
          end
          default: ;
        endcase
      end
      want.channel = chan;
      want.left_distance = left_dist;
      want.right_distance = right_dist;
      expected_readings.push_back(want);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_reading(uer_out_t got);
      uer_out_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result beat, expected none got %p", $time, got);
        errors++;
        return;
      end
      want = expected_readings.pop_front();
      checked++;
      check_field("burst_on", 16'(want.burst_on), 16'(got.burst_on));
      check_field("sampling", 16'(want.sampling), 16'(got.sampling));
      check_field("channel", 16'(want.channel), 16'(got.channel));
      check_field("left_distance", 16'(want.left_distance), 16'(got.left_distance));
      check_field("right_distance", 16'(want.right_distance), 16'(got.right_distance));
      check_field("done_res", 16'(want.done_res), 16'(got.done_res));
      check_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  uer_in_t                in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  uer_out_t               out_data_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i;
  logic [CfgDataBits-1:0] cfg_data_i;

  range_board  board;
  bit          sender_calm;
  bit          hold_request;
  int unsigned long_holds;
  int unsigned cycle_count;

  ultrasonic_echo_ranger u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_reading(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               board.expected_readings.size());
      $display("** ultrasonic_echo_ranger: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, calm stretches, long hold-offs counted here
  initial begin : result_sink
    int unsigned hold, mode_left, r;
    bit calm;
    hold = 0;
    mode_left = 0;
    calm = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold == 0 && (hold_request || $urandom_range(0, 799) == 0)) begin
        hold_request = 1'b0;
        hold = $urandom_range(40, 90);
        long_holds++;
      end
      r = $urandom_range(0, 99);
      if (hold == 0 && !calm && r < 3) hold = $urandom_range(3, 12);
      if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (!calm && r < 25);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_item(input logic op, input logic [SampleBits-1:0] smp);
    uer_in_t beat;
    int unsigned gap;
    beat.opcode = op;
    beat.sample = smp;
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(beat);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (board.expected_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CfgDataBits-1:0] chirp, settle, margin, tmo);
    logic [CfgDataBits-1:0] vals[4];
    logic [CfgIdxBits-1:0]  idxs[4];
    vals = '{chirp, settle, margin, tmo};
    idxs = '{RegChirp, RegSettle, RegMargin, RegTimeout};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idxs[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.write_reg(idxs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_config();
    int unsigned r;
    logic [CfgDataBits-1:0] c, s, m, t;
    r = $urandom_range(0, 9);
    c = CfgDataBits'((r < 7) ? $urandom_range(0, 4) :
                     (r < 9) ? $urandom_range(5, 24) : $urandom_range(0, 255));
    c[CfgDataBits-1:ChirpBits] = (CfgDataBits - ChirpBits)'($urandom);
    r = $urandom_range(0, 9);
    s = CfgDataBits'((r < 7) ? $urandom_range(0, 4) :
                     (r < 9) ? $urandom_range(5, 24) : $urandom_range(0, 255));
    s[CfgDataBits-1:SettleBits] = (CfgDataBits - SettleBits)'($urandom);
    r = $urandom_range(0, 9);
    m = CfgDataBits'((r == 0) ? 0 : (r == 1) ? 1023 :
                     (r < 7) ? $urandom_range(1, 64) : $urandom_range(0, 1023));
    r = $urandom_range(0, 9);
    t = CfgDataBits'((r == 0) ? $urandom_range(0, 1) : (r < 7) ? $urandom_range(2, 40) :
                     (r < 9) ? $urandom_range(41, 300) : $urandom_range(301, 1023));
    write_regs(c, s, m, t);
  endtask

  // one start, then ticks (now and then a second start) until the sequencer falls back to idle
  task automatic run_measurement(input bit calm);
    logic [SampleBits-1:0] last, smp;
    int unsigned r, guard;
    int v;
    bit abandoned;
    sender_calm = calm;
    abandoned = 1'b0;
    guard = 0;
    last = SampleBits'($urandom);
    send_item(OpStart, SampleBits'($urandom));
    while (board.phase != PhIdle && guard < 3000) begin
      guard++;
      if (!abandoned && $urandom_range(0, 199) == 0) begin
        abandoned = 1'b1;
        send_item(OpStart, SampleBits'($urandom));
      end else begin
        if (board.phase != PhSample) begin
          smp = SampleBits'($urandom);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 6) v = int'(last) + int'(board.margin) + 1 + int'($urandom_range(0, 63));
          else if (r < 12) v = int'($urandom_range(0, MaxSample));
          else v = int'(last) + int'($urandom_range(0, 16)) - 8;
          if (v < 0) v = 0;
          if (v > MaxSample) v = MaxSample;
          smp = v[SampleBits-1:0];
        end
        send_item(OpTick, smp);
        last = smp;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned base, phase_no, n;
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegChirp;
    cfg_data_i = '0;
    sender_calm = 1'b0;
    hold_request = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: idle ticks are ignored, then a start and a burst beat
    send_item(OpTick, 12'hFFF);
    send_item(OpTick, 12'h000);
    send_item(OpStart, 12'hAAA);
    send_item(OpTick, 12'h555);
    wait_drain();
    write_regs(10'd1, 10'd0, 10'd0, 10'd1);
    // restart mid-chirp; first sample never echoes; echo and timeout together
    send_item(OpStart, 12'h000);
    send_item(OpTick, 12'h000);
    send_item(OpStart, 12'h000);
    send_item(OpTick, 12'h000);
    send_item(OpTick, 12'h000);
    send_item(OpTick, 12'h000);
    send_item(OpTick, 12'hFFF);
    send_item(OpTick, 12'h000);
    send_item(OpTick, 12'hFFF);
    send_item(OpTick, 12'h123);
    wait_drain();
    write_regs(10'd0, 10'd0, 10'd1023, 10'd1022);
    // widest margin: threshold past the sample range, rise must be strictly greater
    send_item(OpStart, 12'h000);
    send_item(OpTick, 12'h000);
    send_item(OpTick, 12'h000);
    send_item(OpTick, 12'd3072);
    send_item(OpTick, 12'hFFF);
    send_item(OpTick, 12'hFFF);
    send_item(OpTick, 12'h000);
    send_item(OpTick, 12'd1024);
    wait_drain();

    base = board.busy_beats;
    phase_no = 0;
    while (board.busy_beats - base < RandomBeats) begin
      wait_drain();
      case (phase_no)
        0: write_regs(CfgDataBits'(ChirpReset), CfgDataBits'(SettleReset),
                      CfgDataBits'(MarginReset), CfgDataBits'(TimeoutReset));
        1: write_regs(10'd255, 10'd255, 10'($urandom_range(0, 1023)), 10'd1022);
        default: random_config();
      endcase
      if (phase_no == 1) hold_request = 1'b1;
      n = (phase_no < 2) ? 1 : $urandom_range(1, 6);
      repeat (n) begin
        if (board.phase == PhIdle && $urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 2)) send_item(OpTick, SampleBits'($urandom));
        run_measurement(phase_no == 1 || $urandom_range(0, 3) == 0);
      end
      phase_no++;
    end

    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d busy beats, %0d results checked: %0d echoes, %0d timeouts, %0d restarts",
             board.busy_beats, board.checked, board.echoes, board.timeouts,
             board.abandons);
    $display("%0d register writes over %0d settings, %0d long result hold-offs",
             board.reg_writes, phase_no + 3, long_holds);
    if (board.errors == 0) begin
      $display("** ultrasonic_echo_ranger: PASSED **");
    end else begin
      $display("** ultrasonic_echo_ranger: FAILED **");
    end
    $finish;
  end

endmodule

@@ ultrasonic_echo_ranger.f @@
rtl/core/uer_pkg.sv
rtl/core/uer_seq.sv
rtl/core/ultrasonic_echo_ranger.sv
tb/tb_ultrasonic_echo_ranger.sv
